>>> rtl/sbt_pkg.sv
// Shared types and character constants for the s-expression byte tokenizer.
`default_nettype none

package sbt_pkg;

  // Source characters the scanner cares about
  localparam logic [7:0] CHAR_OPEN    = 8'h28;
  localparam logic [7:0] CHAR_CLOSE   = 8'h29;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_BSLASH  = 8'h5C;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_DOT   = 3'd2,
    KIND_NUM   = 3'd3,
    KIND_STR   = 3'd4,
    KIND_ATOM  = 3'd5
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_source;
  } sbt_in_t;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [23:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        unterminated;
    logic        last_of_run;
  } sbt_tok_t;

  // Records the scanner hands to the queue in a single push, first one in rec0
  typedef struct packed {
    logic [1:0] count;
    sbt_tok_t   rec0;
    sbt_tok_t   rec1;
  } sbt_push_t;

endpackage

`default_nettype wire

>>> rtl/sbt_front.sv
// Front end: scans accepted bytes and emits zero, one or two token records.
`default_nettype none

module sbt_front import sbt_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire sbt_in_t   in_i,
  output sbt_push_t      push_o
);

  typedef enum logic [5:0] {
    MODE_IDLE = 6'b000001,
    MODE_INT  = 6'b000010,
    MODE_FRAC = 6'b000100,
    MODE_STR  = 6'b001000,
    MODE_ESC  = 6'b010000,
    MODE_ATOM = 6'b100000
  } mode_e;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pend_start_q, pend_start_d;
  logic [COUNT_BITS-1:0]  pend_len_q, pend_len_d;
  logic [COUNT_BITS-1:0]  pend_line_q, pend_line_d;
  logic [COUNT_BITS-1:0]  pend_col_q, pend_col_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [COUNT_BITS-1:0]  cur_line_q, cur_line_d;
  logic [COUNT_BITS-1:0]  cur_col_q, cur_col_d;

  logic                  flush, single, taken, unterm;
  logic [COUNT_BITS-1:0] flush_len;
  tok_kind_e             flush_kind, single_kind;
  logic [7:0]            c;
  logic                  is_digit, is_alnum, is_sep;
  sbt_tok_t              rec_flush, rec_single;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + CNT_ONE;
  endfunction

  function automatic logic [15:0] to_cnt(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [23:0] to_off(input logic [OFFSET_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[23:0];
  endfunction

  assign c        = in_i.char_in;
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_alnum = is_digit || ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
                    ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
  assign is_sep   = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_NL);

  always_comb begin
    mode_d       = mode_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    pend_line_d  = pend_line_q;
    pend_col_d   = pend_col_q;
    offset_d     = offset_q;
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    flush        = 1'b0;
    single       = 1'b0;
    taken        = 1'b0;
    unterm       = 1'b0;
    flush_len    = pend_len_q;
    single_kind  = KIND_DOT;

    unique case (mode_q)
      MODE_INT, MODE_FRAC: flush_kind = KIND_NUM;
      MODE_STR, MODE_ESC:  flush_kind = KIND_STR;
      default:             flush_kind = KIND_ATOM;
    endcase

    if (accept_i) begin
      if (in_i.end_of_source) begin
        // flush whatever is open, then rewind for the next source
        flush        = (mode_q != MODE_IDLE);
        unterm       = (mode_q == MODE_STR) || (mode_q == MODE_ESC);
        mode_d       = MODE_IDLE;
        pend_start_d = '0;
        pend_len_d   = '0;
        pend_line_d  = CNT_ONE;
        pend_col_d   = CNT_ONE;
        offset_d     = '0;
        cur_line_d   = CNT_ONE;
        cur_col_d    = CNT_ONE;
      end else begin
        unique case (mode_q)
          MODE_INT: begin
            if (is_digit) begin
              pend_len_d = sat_inc(pend_len_q);
              taken      = 1'b1;
            end else if (c == CHAR_DOT) begin
              pend_len_d = sat_inc(pend_len_q);
              mode_d     = MODE_FRAC;
              taken      = 1'b1;
            end else begin
              flush = 1'b1;
            end
          end
          MODE_FRAC: begin
            if (is_digit) begin
              pend_len_d = sat_inc(pend_len_q);
              taken      = 1'b1;
            end else begin
              flush = 1'b1;
            end
          end
          MODE_STR: begin
            pend_len_d = sat_inc(pend_len_q);
            taken      = 1'b1;
            if (c == CHAR_BSLASH) begin
              mode_d = MODE_ESC;
            end else if (c == CHAR_QUOTE) begin
              flush = 1'b1;
            end
          end
          MODE_ESC: begin
            pend_len_d = sat_inc(pend_len_q);
            mode_d     = MODE_STR;
            taken      = 1'b1;
          end
          MODE_ATOM: begin
            if (is_alnum) begin
              pend_len_d = sat_inc(pend_len_q);
              taken      = 1'b1;
            end else begin
              flush = 1'b1;
            end
          end
          default: ;
        endcase

        // a closing string counts its quote in the flushed length
        flush_len = pend_len_d;
        if (flush) begin
          mode_d = MODE_IDLE;
        end

        // the byte that ended a number or atom is scanned again as a fresh byte
        if (!taken) begin
          if ((c == CHAR_OPEN) || (c == CHAR_CLOSE) || (c == CHAR_DOT)) begin
            single = 1'b1;
            if (c == CHAR_OPEN) begin
              single_kind = KIND_OPEN;
            end else if (c == CHAR_CLOSE) begin
              single_kind = KIND_CLOSE;
            end else begin
              single_kind = KIND_DOT;
            end
          end else if (!is_sep) begin
            if (is_digit) begin
              mode_d = MODE_INT;
            end else if (c == CHAR_QUOTE) begin
              mode_d = MODE_STR;
            end else begin
              mode_d = MODE_ATOM;
            end
            pend_start_d = offset_q;
            pend_len_d   = CNT_ONE;
            pend_line_d  = cur_line_q;
            pend_col_d   = cur_col_q;
          end
        end

        offset_d = offset_q + OFFSET_BITS'(1);
        if (c == CHAR_NL) begin
          cur_line_d = sat_inc(cur_line_q);
          cur_col_d  = CNT_ONE;
        end else begin
          cur_col_d = sat_inc(cur_col_q);
        end
      end
    end
  end

  always_comb begin
    rec_flush = '{token_kind:   flush_kind,
                  token_start:  to_off(pend_start_q),
                  token_length: to_cnt(flush_len),
                  token_line:   to_cnt(pend_line_q),
                  token_column: to_cnt(pend_col_q),
                  unterminated: unterm,
                  last_of_run:  !single};
    rec_single = '{token_kind:   single_kind,
                   token_start:  to_off(offset_q),
                   token_length: 16'd1,
                   token_line:   to_cnt(cur_line_q),
                   token_column: to_cnt(cur_col_q),
                   unterminated: 1'b0,
                   last_of_run:  1'b1};
    push_o.count = {1'b0, flush} + {1'b0, single};
    push_o.rec0  = flush ? rec_flush : rec_single;
    push_o.rec1  = rec_single;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      pend_start_q <= '0;
      pend_len_q   <= '0;
      pend_line_q  <= CNT_ONE;
      pend_col_q   <= CNT_ONE;
      offset_q     <= '0;
      cur_line_q   <= CNT_ONE;
      cur_col_q    <= CNT_ONE;
    end else begin
      mode_q       <= mode_d;
      pend_start_q <= pend_start_d;
      pend_len_q   <= pend_len_d;
      pend_line_q  <= pend_line_d;
      pend_col_q   <= pend_col_d;
      offset_q     <= offset_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
    end
  end

  // Two records always mean a flushed number or atom followed by a one-byte token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |->
      ((push_o.rec0.token_kind == KIND_NUM) || (push_o.rec0.token_kind == KIND_ATOM)) &&
      !push_o.rec0.last_of_run && push_o.rec1.last_of_run)
    else $error("two-record push with wrong pairing");

  // An end marker rewinds the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && in_i.end_of_source) |=>
      (offset_q == '0) && (cur_line_q == CNT_ONE) && (cur_col_q == CNT_ONE) &&
      (mode_q == MODE_IDLE))
    else $error("position not rewound after end marker");

  // Only an open string may be flagged unterminated, and only at an end marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count != 2'd0 && push_o.rec0.unterminated) |->
      (in_i.end_of_source && (push_o.rec0.token_kind == KIND_STR)))
    else $error("unterminated flag outside a flushed string");

  // Pending length is never zero while a token is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (pend_len_q != '0))
    else $error("open token with zero length");

endmodule

`default_nettype wire

>>> rtl/sbt_queue.sv
// Token record queue between the scanner and the output stage.
`default_nettype none

module sbt_queue import sbt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire sbt_push_t push_i,
  input  wire logic      pop_i,
  output sbt_tok_t       head_o,
  output logic           empty_o,
  output logic           busy_o
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbt_tok_t           mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   wr_ptr_nx;

  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  assign head_o    = mem_q[rd_ptr_q];
  assign empty_o   = (count_q == '0);
  // hold the input side unless two more records fit
  assign busy_o    = (count_q > CNT_W'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (push_i.count == 2'd0))
    else $error("push into a queue without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

  // Pointer distance tracks the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[PTR_W-1:0])
    else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

>>> rtl/sbt_back.sv
// Back end: output register that drains the record queue one token per cycle unless stalled.
`default_nettype none

module sbt_back import sbt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sbt_tok_t head_i,
  input  wire logic     empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sbt_tok_t      out_data_o
);

  logic     valid_q, valid_d;
  sbt_tok_t data_q;

  // refill when the register is free or its transaction completes
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (valid_q && out_stall_i) begin
      valid_d = 1'b1;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // A record waiting in the queue is never left behind an idle output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_q && !empty_i) |-> pop_o)
    else $error("output idle while queue holds a record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |-> !pop_o)
    else $error("output overwritten while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q)
    else $error("popped record not presented");

endmodule

`default_nettype wire

>>> rtl/sexpr_byte_tokenizer.sv
// S-expression byte tokenizer: scanner, record queue and output stage.
//
// Input channel: one source byte per transaction (in_data_i.char_in), or an end
// marker (in_data_i.end_of_source) that flushes any open token and rewinds the
// offset, line and column for the next source. Output channel: one token record
// per transaction; last_of_run marks the final record an input byte caused.
// Throughput: one byte per cycle while in_stall_o is low. A byte that closes a
// number or atom and is itself a paren or dot yields two records, which leave
// the output one after the other. A record caused by an accepted byte is written
// into the queue and then the output register, which presents it on out_valid_o.
// The scanner writes records into a four-entry queue; in_stall_o is raised
// while more than two records are queued, so a stalled receiver backs up the
// queue and then the input, with no record lost.
// Reset: scan state idle, offset 0, line 1, column 1, queue and output empty.
`default_nettype none

module sexpr_byte_tokenizer import sbt_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire sbt_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output sbt_tok_t     out_data_o
);

  logic      accept;
  logic      q_busy, q_empty, pop;
  sbt_push_t push;
  sbt_tok_t  head;

  assign in_stall_o = q_busy;
  assign accept     = in_valid_i && !q_busy;

  sbt_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (push)
  );

  sbt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .empty_o(q_empty),
    .busy_o (q_busy)
  );

  sbt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
